@@ hw/rtl/deq_pkg.sv @@
`default_nettype none

package deq_pkg;

	// Number of entries in the ring store.
	localparam int DEPTH = 16;
	// Width of one stored value.
	localparam int VALUE_BITS = 32;
	// Index and count widths follow from the depth.
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	// The sum of front index and count is held one bit wider than the count.
	localparam int SUM_W = CNT_W + 1;

	typedef enum logic [1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_BACK  = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_BACK   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STS_OK    = 2'd0,
		STS_EMPTY = 2'd1,
		STS_FULL  = 2'd2
	} status_t;

	// Result information that travels alongside the store read.
	typedef struct packed {
		logic              pop_ok;
		status_t           status;
		logic [CNT_W-1:0]  count;
		logic              empty;
	} meta_t;

	// Store access requested by the control unit.
	typedef struct packed {
		logic                  wr_en;
		logic [IDX_W-1:0]      wr_addr;
		logic [VALUE_BITS-1:0] wr_data;
		logic                  rd_en;
		logic [IDX_W-1:0]      rd_addr;
	} ram_req_t;

endpackage

`default_nettype wire

@@ hw/rtl/double_ended_queue_core.sv @@
// After its request is accepted, a result is registered with the store read, then in the output register.
// Throughput: one request per cycle unless the result channel stalls; a request's pointer update
// and store access, if any, complete in the cycle it is accepted, so the next may follow at once.
// Reset: the front index, the element count and all valid flags are cleared asynchronously;
// the store itself is not cleared, as an entry is only ever read after it has been written.
`default_nettype none

module double_ended_queue_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Request channel.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // [31:0] push_value
	input  wire logic [1:0]  s_tuser,  // [1:0] operation
	// Result channel.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [39:0] m_tdata,  // [31:0] pop_value, [36:32] element_count,
	                                   // [37] is_empty, [39:38] zero
	output logic      [1:0]  m_tuser   // [1:0] status
);

	import deq_pkg::*;

	// The request is accepted in the same cycle that its pointers are updated and
	// its store write or read is issued.
	logic      req_fire;
	ram_req_t  ram_req;
	meta_t     meta;
	logic [VALUE_BITS-1:0] rd_data;

	// Stage one holds the result information while the store read completes.
	logic  valid_s1;
	meta_t meta_s1;
	logic  adv_s1;

	// The output register lets stage one take a fresh request while a finished
	// item is still waiting at the result channel.
	logic                  out_valid_q;
	logic [31:0]           pop_value_q;
	status_t               status_q;
	logic [CNT_W-1:0]      count_q;
	logic                  empty_q;

	assign adv_s1   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;
	assign req_fire = s_tvalid && s_tready;

	deq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_fire   (req_fire),
		.op         (op_t'(s_tuser)),
		.push_value (s_tdata[VALUE_BITS-1:0]),
		.ram_req    (ram_req),
		.meta       (meta)
	);

	// A stalled stage one issues no new read, so the read data holds with it.
	deq_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_req.wr_en),
		.wr_addr (ram_req.wr_addr),
		.wr_data (ram_req.wr_data),
		.rd_en   (ram_req.rd_en),
		.rd_addr (ram_req.rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			meta_s1 <= meta;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Pushes and failed pops report a zero value.
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			pop_value_q <= meta_s1.pop_ok ? rd_data : '0;
			status_q    <= meta_s1.status;
			count_q     <= meta_s1.count;
			empty_q     <= meta_s1.empty;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, empty_q, count_q, pop_value_q};
	assign m_tuser  = status_q;

endmodule

`default_nettype wire

@@ hw/rtl/deq_ram.sv @@
`default_nettype none

module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                                       clk,
	input  wire logic                                       wr_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                           wr_data,
	input  wire logic                                       rd_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                           rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/deq_ctrl.sv @@
`default_nettype none

module deq_ctrl (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           req_fire,
	input  wire deq_pkg::op_t                   op,
	input  wire logic [deq_pkg::VALUE_BITS-1:0] push_value,
	output deq_pkg::ram_req_t                   ram_req,
	output deq_pkg::meta_t                      meta
);

	import deq_pkg::*;

	logic [IDX_W-1:0] front_q;
	logic [CNT_W-1:0] count_q;

	logic [IDX_W-1:0] front_nxt;
	logic [CNT_W-1:0] count_nxt;
	logic [IDX_W-1:0] front_dec;
	logic [IDX_W-1:0] front_inc;
	logic [SUM_W-1:0] back_sum;
	logic [IDX_W-1:0] back_idx;
	logic             is_full;
	logic             is_empty;

	always_comb begin
		is_full  = (count_q == CNT_W'(DEPTH));
		is_empty = (count_q == '0);

		front_dec = (front_q == '0) ? IDX_W'(DEPTH - 1) : front_q - 1'b1;
		front_inc = (front_q == IDX_W'(DEPTH - 1)) ? '0 : front_q + 1'b1;

		// The back slot for a push sits one past the last element; a pop reads the last.
		back_sum = SUM_W'(front_q) + SUM_W'(count_q)
			- SUM_W'(op == OP_POP_BACK);
		back_idx = (back_sum >= SUM_W'(DEPTH)) ? IDX_W'(back_sum - SUM_W'(DEPTH))
			: IDX_W'(back_sum);

		front_nxt       = front_q;
		count_nxt       = count_q;
		ram_req.wr_en   = 1'b0;
		ram_req.wr_addr = back_idx;
		ram_req.wr_data = push_value;
		ram_req.rd_en   = 1'b0;
		ram_req.rd_addr = back_idx;
		meta.pop_ok     = 1'b0;
		meta.status     = STS_OK;

		case (op)
			OP_PUSH_FRONT: begin
				if (is_full) begin
					meta.status = STS_FULL;
				end else begin
					front_nxt       = front_dec;
					count_nxt       = count_q + 1'b1;
					ram_req.wr_en   = req_fire;
					ram_req.wr_addr = front_dec;
				end
			end
			OP_PUSH_BACK: begin
				if (is_full) begin
					meta.status = STS_FULL;
				end else begin
					count_nxt     = count_q + 1'b1;
					ram_req.wr_en = req_fire;
				end
			end
			OP_POP_FRONT: begin
				if (is_empty) begin
					meta.status = STS_EMPTY;
				end else begin
					front_nxt       = front_inc;
					count_nxt       = count_q - 1'b1;
					ram_req.rd_en   = req_fire;
					ram_req.rd_addr = front_q;
					meta.pop_ok     = 1'b1;
				end
			end
			OP_POP_BACK: begin
				if (is_empty) begin
					meta.status = STS_EMPTY;
				end else begin
					count_nxt     = count_q - 1'b1;
					ram_req.rd_en = req_fire;
					meta.pop_ok   = 1'b1;
				end
			end
			default: begin
				meta.status = STS_OK;
			end
		endcase

		meta.count = count_nxt;
		meta.empty = (count_nxt == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else if (req_fire) begin
			front_q <= front_nxt;
			count_q <= count_nxt;
		end
	end

endmodule

`default_nettype wire

@@ tb/sv/double_ended_queue_core_tb.sv @@
`default_nettype none

// Checks the double-ended queue core against a behavioural copy of the deque.
// A queue of requests is filled up front. It holds a short directed opening, then random
// epochs that favour pushes, pops or neither, so that the store runs full and empty many times over.
// A clocked driver feeds the requests in bursts with random gaps. A clocked monitor takes the
// results under a rotating back-pressure pattern. Each result is compared field by field with
// the oldest expected one.
module double_ended_queue_core_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import deq_pkg::*;

	localparam int RANDOM_ITEMS = 600;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 200000;

	// One request as it travels on the slave side.
	typedef struct packed {
		op_t                   op;
		logic [VALUE_BITS-1:0] value;
	} request_t;

	// One result as the monitor expects to see it.
	typedef struct packed {
		logic [VALUE_BITS-1:0] pop_value;
		status_t               status;
		logic [CNT_W-1:0]      count;
		logic                  empty;
	} outcome_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;
	logic [1:0]  s_tuser  = OP_PUSH_FRONT;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;

	request_t request_q[$];
	outcome_t outcome_q[$];
	request_t on_bus;

	// Shadow copy of the deque held by the predictor.
	logic [VALUE_BITS-1:0] shadow_store [DEPTH];
	logic [IDX_W-1:0]      shadow_front = '0;
	logic [CNT_W-1:0]      shadow_count = '0;

	int          error_count = 0;
	int          cycle_count = 0;
	int          burst_left  = 0;
	int          gap_left    = 0;
	int          ready_phase = 0;
	logic [7:0]  ready_pattern = 8'hFF;

	double_ended_queue_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Applies one request to the shadow deque and returns the result it must produce.
	// A push onto a full deque and a pop from an empty one leave the state untouched.
	function automatic outcome_t deque_update(request_t req);
		outcome_t         res;
		logic [IDX_W-1:0] slot;
		res = '0;
		res.status = STS_OK;
		case (req.op)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (shadow_count >= DEPTH) begin
					res.status = STS_FULL;
				end else begin
					if (req.op == OP_PUSH_FRONT) begin
						shadow_front = (shadow_front == 0) ? IDX_W'(DEPTH - 1)
						                                   : shadow_front - 1'b1;
						shadow_store[shadow_front] = req.value;
					end else begin
						slot = IDX_W'((int'(shadow_front) + int'(shadow_count)) % DEPTH);
						shadow_store[slot] = req.value;
					end
					shadow_count = shadow_count + 1'b1;
				end
			end
			default: begin
				if (shadow_count == 0) begin
					res.status = STS_EMPTY;
				end else begin
					if (req.op == OP_POP_FRONT) begin
						res.pop_value = shadow_store[shadow_front];
						shadow_front = IDX_W'((int'(shadow_front) + 1) % DEPTH);
					end else begin
						slot = IDX_W'((int'(shadow_front) + int'(shadow_count) - 1) % DEPTH);
						res.pop_value = shadow_store[slot];
					end
					// Taking the last element from either end leaves the deque empty.
					shadow_count = shadow_count - 1'b1;
				end
			end
		endcase
		res.count = shadow_count;
		res.empty = (shadow_count == 0);
		return res;
	endfunction

	task automatic compare_field(input string fname, input logic [31:0] want,
	                             input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, fname, want, got);
			error_count++;
		end
	endtask

	task automatic add_request(input op_t op, input logic [31:0] value);
		request_t req;
		req.op = op;
		req.value = value;
		request_q.push_back(req);
	endtask

	// Driver. The item on the bus is predicted at the edge that accepts it, then the next
	// one is loaded unless the sender is in a gap or has none left. Valid is never dropped while it waits.
	always @(posedge clk) begin
		logic load;
		load = 1'b0;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= OP_PUSH_FRONT;
		end else begin
			if (s_tvalid && s_tready)
				outcome_q.push_back(deque_update(on_bus));
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (request_q.size() != 0) begin
					on_bus = request_q.pop_front();
					load = 1'b1;
					s_tdata <= on_bus.value;
					s_tuser <= on_bus.op;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						// Mostly short bursts, now and then a long stretch without idling.
						burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
						                                         : $urandom_range(1, 12);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
				s_tvalid <= load;
			end
		end
	end

	// Receiver back-pressure: an eight-bit pattern rotates each cycle and is reloaded now
	// and then, either all ones or a random pattern with at least one ready slot.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (ready_phase == 0) begin
				ready_pattern = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom()) | 8'h01);
				ready_phase = $urandom_range(8, 64);
			end
			ready_phase--;
			m_tready <= ready_pattern[0];
			ready_pattern = {ready_pattern[0], ready_pattern[7:1]};
		end
	end

	// Monitor.
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (outcome_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual tdata %0h tuser %0h",
				         $realtime, m_tdata, m_tuser);
				error_count++;
			end else begin
				want = outcome_q.pop_front();
				compare_field("pop_value", want.pop_value, m_tdata[31:0]);
				compare_field("element_count", 32'(want.count), 32'(m_tdata[36:32]));
				compare_field("is_empty", 32'(want.empty), 32'(m_tdata[37]));
				compare_field("tdata padding", 32'd0, 32'(m_tdata[39:38]));
				compare_field("status", 32'(want.status), 32'(m_tuser));
			end
		end
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("FAILURE");
		$finish;
	end

	initial begin
		int          issued;
		int          epoch_len;
		int          push_pct;
		int          k;
		logic        is_push;
		logic        at_front;
		logic [31:0] value;
		op_t         op;

		// Directed opening: pops on an empty deque, the last element taken from either
		// end, the front index wrapping below zero, then a fill to capacity and pushes
		// at both ends against a full store.
		add_request(OP_POP_FRONT, 32'h1234_5678);
		add_request(OP_POP_BACK, 32'hFFFF_FFFF);
		add_request(OP_PUSH_FRONT, 32'h8000_0000);
		add_request(OP_POP_BACK, 32'h0);
		add_request(OP_PUSH_BACK, 32'h7FFF_FFFF);
		add_request(OP_POP_FRONT, 32'h0);
		add_request(OP_PUSH_BACK, 32'h0);
		for (k = 1; k < DEPTH; k++) begin
			case (k % 4)
				0: value = 32'hFFFF_FFFF;
				1: value = 32'h5555_5555;
				2: value = 32'hAAAA_AAAA;
				default: value = 32'($urandom());
			endcase
			add_request((k % 2 == 0) ? OP_PUSH_FRONT : OP_PUSH_BACK, value);
		end
		add_request(OP_PUSH_FRONT, 32'h8000_0000);
		add_request(OP_PUSH_BACK, 32'h7FFF_FFFF);

		// Each random epoch is picked at random among filling, draining and a balanced mix.
		issued = 0;
		while (issued < RANDOM_ITEMS) begin
			epoch_len = $urandom_range(10, 50);
			case ($urandom_range(0, 2))
				0: push_pct = 80;
				1: push_pct = 20;
				default: push_pct = 50;
			endcase
			for (k = 0; k < epoch_len; k++) begin
				is_push = ($urandom_range(0, 99) < push_pct);
				at_front = $urandom_range(0, 1);
				if (is_push)
					op = at_front ? OP_PUSH_FRONT : OP_PUSH_BACK;
				else
					op = at_front ? OP_POP_FRONT : OP_POP_BACK;
				case ($urandom_range(0, 15))
					0: value = 32'h8000_0000;
					1: value = 32'h7FFF_FFFF;
					2: value = 32'h0;
					3: value = 32'hFFFF_FFFF;
					default: value = 32'($urandom());
				endcase
				add_request(op, value);
				issued++;
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (request_q.size() != 0 || s_tvalid || outcome_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire
